### design/dacs_pkg.sv
// Shared types, codes and constants of the door auto-close sequencer.
// Used by dacs_regs, dacs_core and door_auto_close_sequencer_top; no dependencies.
`timescale 1ns / 1ps

package dacs_pkg;

  // Timing constants of the sequence.
  localparam int TICK_MS           = 100;
  localparam int TRIGGER_WINDOW_MS = 5000;
  localparam int MS_PER_S          = 1000;
  localparam int S_PER_HOUR        = 3600;
  localparam int HOUR_NEVER        = 24;
  localparam int MOVE_GRACE_MS     = 1000;
  localparam int LOCKOUT_MS        = TRIGGER_WINDOW_MS + 1000;

  localparam int ELAPSED_W = 22;
  localparam int SEC_W     = 17;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Register file layout.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [2:0] REG_CLOSE_HOUR   = 3'd0;
  localparam logic [2:0] REG_PREWARN      = 3'd1;
  localparam logic [2:0] REG_PAUSE        = 3'd2;
  localparam logic [2:0] REG_ERROR_WAIT   = 3'd3;
  localparam logic [2:0] REG_VENT_TIMEOUT = 3'd4;
  localparam logic [2:0] REG_VENT_HOLD    = 3'd5;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_AUTO   = 2'd1;
  localparam logic [1:0] OP_PARCEL = 2'd2;
  localparam logic [1:0] OP_ABORT  = 2'd3;

  // Action codes of a result beat.
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_CLOSE = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_VENT  = 2'd3;

  // Phase codes as they appear on the result channel.
  localparam logic [3:0] PHC_IDLE    = 4'd0;
  localparam logic [3:0] PHC_START   = 4'd1;
  localparam logic [3:0] PHC_PREWARN = 4'd2;
  localparam logic [3:0] PHC_PAUSE   = 4'd3;
  localparam logic [3:0] PHC_CLOSING = 4'd4;
  localparam logic [3:0] PHC_LOCKOUT = 4'd5;
  localparam logic [3:0] PHC_ERRFIX  = 4'd6;
  localparam logic [3:0] PHC_PSTART  = 4'd7;
  localparam logic [3:0] PHC_TOVENT  = 4'd8;
  localparam logic [3:0] PHC_HOLD    = 4'd9;

  // Internal phase state, one-hot.
  typedef enum logic [9:0] {
    PH_IDLE    = 10'b00_0000_0001,
    PH_START   = 10'b00_0000_0010,
    PH_PREWARN = 10'b00_0000_0100,
    PH_PAUSE   = 10'b00_0000_1000,
    PH_CLOSING = 10'b00_0001_0000,
    PH_LOCKOUT = 10'b00_0010_0000,
    PH_ERRFIX  = 10'b00_0100_0000,
    PH_PSTART  = 10'b00_1000_0000,
    PH_TOVENT  = 10'b01_0000_0000,
    PH_HOLD    = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic             force_stop;
    logic             door_closed;
    logic             door_error;
    logic             door_moving;
    logic             door_vent_position;
    logic [SEC_W-1:0] second_of_day;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] phase;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  close_hour;
    logic [7:0]  prewarn_seconds;
    logic [7:0]  pause_seconds;
    logic [15:0] error_wait_ms;
    logic [7:0]  vent_timeout_seconds;
    logic [11:0] vent_hold_seconds;
  } cfg_t;

  // Maps the one-hot phase onto its external code.
  function automatic logic [3:0] phase_code(phase_t ph);
    logic [3:0] code;
    case (ph)
      PH_IDLE:    code = PHC_IDLE;
      PH_START:   code = PHC_START;
      PH_PREWARN: code = PHC_PREWARN;
      PH_PAUSE:   code = PHC_PAUSE;
      PH_CLOSING: code = PHC_CLOSING;
      PH_LOCKOUT: code = PHC_LOCKOUT;
      PH_ERRFIX:  code = PHC_ERRFIX;
      PH_PSTART:  code = PHC_PSTART;
      PH_TOVENT:  code = PHC_TOVENT;
      PH_HOLD:    code = PHC_HOLD;
      default:    code = PHC_IDLE;
    endcase
    return code;
  endfunction

endpackage

### design/dacs_regs.sv
// Configuration register file of the door auto-close sequencer, APB-style access.
// Depends on dacs_pkg.
`timescale 1ns / 1ps

module dacs_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dacs_pkg::ADDR_W-1:0] paddr,
  input  logic [dacs_pkg::DATA_W-1:0] pwdata,
  output logic [dacs_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output dacs_pkg::cfg_t              cfg
);
  import dacs_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg     = cfg_r;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.close_hour           <= 5'(HOUR_NEVER);
      cfg_r.prewarn_seconds      <= 8'd5;
      cfg_r.pause_seconds        <= 8'd10;
      cfg_r.error_wait_ms        <= 16'd5000;
      cfg_r.vent_timeout_seconds <= 8'd60;
      cfg_r.vent_hold_seconds    <= 12'd600;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CLOSE_HOUR:   cfg_r.close_hour           <= pwdata[4:0];
        REG_PREWARN:      cfg_r.prewarn_seconds      <= pwdata[7:0];
        REG_PAUSE:        cfg_r.pause_seconds        <= pwdata[7:0];
        REG_ERROR_WAIT:   cfg_r.error_wait_ms        <= pwdata[15:0];
        REG_VENT_TIMEOUT: cfg_r.vent_timeout_seconds <= pwdata[7:0];
        REG_VENT_HOLD:    cfg_r.vent_hold_seconds    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Read mux, zero-extended to the bus width.
  always_comb begin
    case (reg_idx)
      REG_CLOSE_HOUR:   prdata = DATA_W'(cfg_r.close_hour);
      REG_PREWARN:      prdata = DATA_W'(cfg_r.prewarn_seconds);
      REG_PAUSE:        prdata = DATA_W'(cfg_r.pause_seconds);
      REG_ERROR_WAIT:   prdata = DATA_W'(cfg_r.error_wait_ms);
      REG_VENT_TIMEOUT: prdata = DATA_W'(cfg_r.vent_timeout_seconds);
      REG_VENT_HOLD:    prdata = DATA_W'(cfg_r.vent_hold_seconds);
      default:          prdata = '0;
    endcase
  end

endmodule

### design/dacs_core.sv
// Phase and elapsed-time state of the door auto-close sequencer with its update logic.
// Depends on dacs_pkg; fed by the input register in the top level.
`timescale 1ns / 1ps

module dacs_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  dacs_pkg::in_item_t  item,
  input  dacs_pkg::cfg_t      cfg,
  output dacs_pkg::out_item_t result
);
  import dacs_pkg::*;

  phase_t                phase_r, phase_nxt, ph_eff;
  logic [ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic [ELAPSED_W:0]    el_sum;
  logic [ELAPSED_W-1:0]  el_tick;
  logic [SEC_W-1:0]      win_start;
  logic [SEC_W:0]        win_end;
  logic                  trig;
  logic [ELAPSED_W-1:0]  thr_prewarn, thr_pause, thr_vent_to, thr_hold;
  logic [1:0]            act;

  // Saturating elapsed-time advance for a tick.
  assign el_sum  = {1'b0, elapsed_r} + (ELAPSED_W+1)'(TICK_MS);
  assign el_tick = (el_sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : el_sum[ELAPSED_W-1:0];

  // Scheduled-hour trigger window, only taken from idle.
  assign win_start = SEC_W'(32'(cfg.close_hour) * S_PER_HOUR);
  assign win_end   = (SEC_W+1)'(win_start) + (SEC_W+1)'(TRIGGER_WINDOW_MS / MS_PER_S);
  assign trig      = (cfg.close_hour < 5'(HOUR_NEVER))
                     && (item.second_of_day >= win_start)
                     && ((SEC_W+1)'(item.second_of_day) <= win_end)
                     && (phase_r == PH_IDLE);

  // Second-based limits scaled to milliseconds.
  assign thr_prewarn = ELAPSED_W'(32'(cfg.prewarn_seconds) * MS_PER_S);
  assign thr_pause   = ELAPSED_W'(32'(cfg.pause_seconds) * MS_PER_S);
  assign thr_vent_to = ELAPSED_W'(32'(cfg.vent_timeout_seconds) * MS_PER_S);
  assign thr_hold    = ELAPSED_W'(32'(cfg.vent_hold_seconds) * MS_PER_S);

  // Next phase, elapsed time and action for the current beat.
  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    ph_eff      = phase_r;
    act         = ACT_NONE;
    case (item.operation)
      OP_TICK: begin
        elapsed_nxt = el_tick;
        if (trig) begin
          ph_eff = PH_START;
        end
        phase_nxt = ph_eff;
        case (ph_eff)
          PH_START: begin
            act         = ACT_CLOSE;
            phase_nxt   = PH_PREWARN;
            elapsed_nxt = '0;
          end
          PH_PREWARN: begin
            if (el_tick > thr_prewarn) begin
              act         = ACT_STOP;
              phase_nxt   = PH_PAUSE;
              elapsed_nxt = '0;
            end
          end
          PH_PAUSE: begin
            if (el_tick > thr_pause) begin
              act         = ACT_CLOSE;
              phase_nxt   = PH_CLOSING;
              elapsed_nxt = '0;
            end else if (item.door_moving && el_tick > ELAPSED_W'(MOVE_GRACE_MS)) begin
              phase_nxt   = PH_LOCKOUT;
              elapsed_nxt = '0;
            end
          end
          PH_CLOSING, PH_LOCKOUT: begin
            if (el_tick > ELAPSED_W'(LOCKOUT_MS)) begin
              phase_nxt   = PH_IDLE;
              elapsed_nxt = '0;
            end
          end
          PH_ERRFIX: begin
            if (el_tick > ELAPSED_W'(cfg.error_wait_ms)) begin
              phase_nxt = PH_PSTART;
            end
          end
          PH_PSTART: begin
            act         = ACT_VENT;
            phase_nxt   = PH_TOVENT;
            elapsed_nxt = '0;
          end
          PH_TOVENT: begin
            if (item.door_vent_position || el_tick > thr_vent_to) begin
              phase_nxt   = PH_HOLD;
              elapsed_nxt = '0;
            end
          end
          PH_HOLD: begin
            // The timer keeps running into the closing phase.
            if (el_tick > thr_hold) begin
              act       = ACT_CLOSE;
              phase_nxt = PH_CLOSING;
            end
          end
          default: ;
        endcase
      end
      OP_AUTO: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt = PH_START;
        end
      end
      OP_PARCEL: begin
        if (phase_r == PH_IDLE && item.door_closed) begin
          if (item.door_error) begin
            act         = ACT_CLOSE;
            phase_nxt   = PH_ERRFIX;
            elapsed_nxt = '0;
          end else begin
            phase_nxt = PH_PSTART;
          end
        end
      end
      OP_ABORT: begin
        phase_nxt   = PH_LOCKOUT;
        elapsed_nxt = '0;
        if (item.force_stop) begin
          act = ACT_STOP;
        end
      end
      default: ;
    endcase
  end

  assign result.action = act;
  assign result.phase  = phase_code(phase_nxt);

  // State update on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
    end else if (en) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // An abort always lands in the lockout with a cleared timer.
  a_abort_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.operation == OP_ABORT |=> phase_r == PH_LOCKOUT && elapsed_r == '0)
    else $error("abort did not enter lockout with cleared timer");

  // Without a beat the state does not move.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(phase_r) && $stable(elapsed_r))
    else $error("state changed without a beat");

  // An auto-close request outside idle leaves the state untouched.
  a_busy_request: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.operation == OP_AUTO && phase_r != PH_IDLE
    |=> $stable(phase_r) && $stable(elapsed_r))
    else $error("auto-close request changed a busy sequence");

endmodule

### design/door_auto_close_sequencer_top.sv
// Top level of the door auto-close sequencer: handshake registers and instances.
// Depends on dacs_pkg, dacs_regs and dacs_core.
`timescale 1ns / 1ps

// The sequencer takes one input beat per clock cycle while out_ready allows it
// and returns exactly one result beat for it. A beat is captured in an input
// register, processed by the phase logic once the result register is free or
// being drained, and written to the result register. The sustained throughput
// is one beat per cycle while out_ready stays high; the phase and timer update
// feeds the next beat directly. A result waiting on out_ready holds back at
// most the one beat in the input register. Configuration registers sit at byte
// addresses 0 to 20; the user must write them only while no beat is in flight,
// and the block itself does not enforce this.
module door_auto_close_sequencer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dacs_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dacs_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dacs_pkg::ADDR_W-1:0] paddr,
  input  logic [dacs_pkg::DATA_W-1:0] pwdata,
  output logic [dacs_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import dacs_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_data_r;
  logic      s1_valid_r;
  out_item_t out_data_r, result;
  logic      out_valid_r;
  logic      fire;

  dacs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dacs_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (fire),
    .item   (s1_data_r),
    .cfg    (cfg),
    .result (result)
  );

  // A held beat moves on when the result register is free or being drained.
  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every processed beat shows up as a result.
  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed beat produced no result");

  // An accepted beat is held in the input register.
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted beat was lost");

endmodule
